>>> sv/bfa_pkg.sv
// Shared types, constants and helper functions for the bitmap frame allocator.
// No dependencies; used by bfa_ctrl, bfa_dp and bitmap_frame_allocator_top.
package bfa_pkg;

    localparam int FRAMES     = 4096;
    localparam int WORD_BITS  = 32;
    localparam int WORDS      = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(WORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int LIMIT_W    = 13;
    localparam int CNT_W      = LIMIT_W - BIT_IDX_W;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_MAPPED  = 2'd1,
        ST_NO_FREE = 2'd2,
        ST_NOTHING = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_FREE_WR,
        S_RESP
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic    load_item;
        logic    rd_entry;
        logic    rd_first;
        logic    scan_next;
        logic    wr_alloc;
        logic    wr_free;
        logic    set_res;
        status_t res_code;
        logic    load_out;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic item_free;
        logic entry_zero;
        logic limit_zero;
        logic word_hit;
        logic last_word;
        logic out_busy;
    } stat_t;

    // Lowest clear bit of a word: {found, index}
    function automatic logic [BIT_IDX_W:0] first_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W:0] r;
        r = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r = {1'b1, BIT_IDX_W'(i)};
            end
        end
        return r;
    endfunction

endpackage

>>> sv/bfa_ctrl.sv
// Controller state machine for the bitmap frame allocator.
// Depends on bfa_pkg; drives bfa_dp through cmd_t and reads stat_t.
module bfa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bfa_pkg::stat_t stat,
    output bfa_pkg::cmd_t  cmd
);

    bfa_pkg::state_t state_reg;
    bfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bfa_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.res_code = bfa_pkg::ST_DONE;
        case (state_reg)
            bfa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = bfa_pkg::S_DECODE;
                end
            end
            bfa_pkg::S_DECODE:
            begin
                if (!stat.item_free) begin
                    if (!stat.entry_zero) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = bfa_pkg::ST_MAPPED;
                        state_next   = bfa_pkg::S_RESP;
                    end else if (stat.limit_zero) begin
                        cmd.set_res  = 1'b1;
                        cmd.res_code = bfa_pkg::ST_NO_FREE;
                        state_next   = bfa_pkg::S_RESP;
                    end else begin
                        cmd.rd_first = 1'b1;
                        state_next   = bfa_pkg::S_SCAN;
                    end
                end else if (stat.entry_zero) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = bfa_pkg::ST_NOTHING;
                    state_next   = bfa_pkg::S_RESP;
                end else begin
                    cmd.rd_entry = 1'b1;
                    state_next   = bfa_pkg::S_FREE_WR;
                end
            end
            bfa_pkg::S_SCAN:
            begin
                if (stat.word_hit) begin
                    cmd.wr_alloc = 1'b1;
                    state_next   = bfa_pkg::S_RESP;
                end else if (stat.last_word) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = bfa_pkg::ST_NO_FREE;
                    state_next   = bfa_pkg::S_RESP;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            bfa_pkg::S_FREE_WR:
            begin
                cmd.wr_free = 1'b1;
                state_next  = bfa_pkg::S_RESP;
            end
            bfa_pkg::S_RESP:
            begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = bfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bfa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/bfa_dp.sv
// Datapath of the bitmap frame allocator: bitmap memory, scan pointer,
// limit register, result and output registers. Depends on bfa_pkg.
module bfa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfa_pkg::cmd_t                 cmd,
    output bfa_pkg::stat_t                stat,
    input  logic                          cfg_valid,
    input  logic [bfa_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                          mode,
    input  logic [bfa_pkg::FRAME_W-1:0]   entry_frame,
    input  logic                          kernel_flag,
    input  logic                          writable_flag,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bfa_pkg::FRAME_W-1:0]   new_frame,
    output logic                          present_bit,
    output logic                          rw_bit,
    output logic                          user_bit
);

    localparam int WB = bfa_pkg::WORD_BITS;
    localparam int AW = bfa_pkg::WORD_IDX_W;
    localparam int BW = bfa_pkg::BIT_IDX_W;
    localparam int FW = bfa_pkg::FRAME_W;
    localparam int CW = bfa_pkg::CNT_W;

    // Bitmap store with per-word valid bits; an unwritten word reads as all free
    logic [WB-1:0]            mem [bfa_pkg::WORDS];
    logic [bfa_pkg::WORDS-1:0] vld_reg;
    logic [WB-1:0]            rd_data_reg;
    logic                     rd_vld_reg;

    logic [bfa_pkg::LIMIT_W-1:0] limit_reg;
    logic                        mode_reg;
    logic [FW-1:0]               entry_reg;
    logic                        kernel_reg;
    logic                        writable_reg;
    logic [AW-1:0]               chk_reg;

    bfa_pkg::status_t res_status_reg;
    logic [FW-1:0]    res_frame_reg;
    logic             res_flags_reg;

    logic                    out_valid_reg;
    bfa_pkg::status_t        out_status_reg;
    logic [FW-1:0]           out_frame_reg;
    logic                    out_present_reg;
    logic                    out_rw_reg;
    logic                    out_user_reg;

    logic [WB-1:0] word_eff;
    logic [BW:0]   hit;
    logic [CW-1:0] lim_words_raw;
    logic [CW-1:0] lim_words;
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic [AW-1:0] wr_addr;
    logic [WB-1:0] wr_data;
    logic          wr_en;

    assign word_eff      = rd_vld_reg ? rd_data_reg : '0;
    assign hit           = bfa_pkg::first_zero(word_eff);
    assign lim_words_raw = limit_reg[bfa_pkg::LIMIT_W-1:BW];
    assign lim_words     = (lim_words_raw > CW'(bfa_pkg::WORDS)) ?
                           CW'(bfa_pkg::WORDS) : lim_words_raw;

    assign stat.item_free  = mode_reg;
    assign stat.entry_zero = (entry_reg == '0);
    assign stat.limit_zero = (lim_words == '0);
    assign stat.word_hit   = hit[BW];
    assign stat.last_word  = (CW'(chk_reg) == lim_words - CW'(1));
    assign stat.out_busy   = out_valid_reg && !out_ready;

    // Read and write addresses, enables and write data
    always_comb begin
        rd_en   = cmd.rd_entry || cmd.rd_first || cmd.scan_next;
        rd_addr = '0;
        if (cmd.rd_entry) begin
            rd_addr = entry_reg[FW-1:BW];
        end else if (cmd.scan_next) begin
            rd_addr = chk_reg + AW'(1);
        end
        wr_en   = cmd.wr_alloc || cmd.wr_free;
        wr_addr = cmd.wr_alloc ? chk_reg : entry_reg[FW-1:BW];
        if (cmd.wr_alloc) begin
            wr_data = word_eff | (WB'(1) << hit[BW-1:0]);
        end else begin
            wr_data = word_eff & ~(WB'(1) << entry_reg[BW-1:0]);
        end
    end

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Limit register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            limit_reg <= bfa_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    // Item, scan pointer and pending result
    always_ff @(posedge clk) begin
        if (cmd.load_item) begin
            mode_reg     <= mode;
            entry_reg    <= entry_frame;
            kernel_reg   <= kernel_flag;
            writable_reg <= writable_flag;
        end
        if (cmd.rd_first) begin
            chk_reg <= '0;
        end else if (cmd.scan_next) begin
            chk_reg <= chk_reg + AW'(1);
        end
        if (cmd.wr_alloc) begin
            res_status_reg <= bfa_pkg::ST_DONE;
            res_frame_reg  <= {chk_reg, hit[BW-1:0]};
            res_flags_reg  <= 1'b1;
        end else if (cmd.wr_free) begin
            res_status_reg <= bfa_pkg::ST_DONE;
            res_frame_reg  <= '0;
            res_flags_reg  <= 1'b0;
        end else if (cmd.set_res) begin
            res_status_reg <= cmd.res_code;
            res_frame_reg  <= (cmd.res_code == bfa_pkg::ST_MAPPED) ? entry_reg : '0;
            res_flags_reg  <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_out) begin
            out_status_reg  <= res_status_reg;
            out_frame_reg   <= res_frame_reg;
            out_present_reg <= res_flags_reg;
            out_rw_reg      <= res_flags_reg && writable_reg;
            out_user_reg    <= res_flags_reg && !kernel_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign new_frame   = out_frame_reg;
    assign present_bit = out_present_reg;
    assign rw_bit      = out_rw_reg;
    assign user_bit    = out_user_reg;

endmodule

>>> sv/bitmap_frame_allocator_top.sv
// Bitmap frame allocator, top level: ties the controller to the datapath.
// Depends on bfa_pkg, bfa_ctrl and bfa_dp.
//
// One item is in work at a time. An allocate scans the bitmap words in
// turn until a free bit turns up, reading at most frame_limit/32 words,
// capped at 128; the bitmap memory returns one 32-bit word a cycle to the
// scan. A free reads one word and writes it back; an allocate into a
// mapped entry and a free of frame 0 go from decode straight to the
// result. The result sits in an output register, so the next input
// transaction is taken while it waits; a new result waits in turn until
// that register is emptied. The bitmap starts all free straight out of
// reset through per-word valid bits, with no clearing pass.
// frame_limit is written through the cfg channel, which is always ready;
// write it only while the block is idle.
module bitmap_frame_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bfa_pkg::LIMIT_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        mode,
    input  logic [bfa_pkg::FRAME_W-1:0] entry_frame,
    input  logic                        kernel_flag,
    input  logic                        writable_flag,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [bfa_pkg::FRAME_W-1:0] new_frame,
    output logic                        present_bit,
    output logic                        rw_bit,
    output logic                        user_bit
);

    bfa_pkg::cmd_t  cmd;
    bfa_pkg::stat_t stat;

    // Hold cfg ready: writes land in the limit register at once
    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .mode          (mode),
        .entry_frame   (entry_frame),
        .kernel_flag   (kernel_flag),
        .writable_flag (writable_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .new_frame     (new_frame),
        .present_bit   (present_bit),
        .rw_bit        (rw_bit),
        .user_bit      (user_bit)
    );

`ifndef ASSERT_OFF
    // One item at a time: no second transaction straight after the first
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in work");

    // Entry bits are clear on every result whose status is not done
    a_flags_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != 2'(bfa_pkg::ST_DONE)) |->
        (!present_bit && !rw_bit && !user_bit))
        else $error("entry bits set on a failed transaction");

    // An allocate write happens only when the scanned word has a free bit
    a_alloc_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_alloc |-> stat.word_hit)
        else $error("allocate write without a free bit");

    // Result never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.load_out)
        else $error("result register overwritten");
`endif

endmodule

>>> test/frame_alloc_checker.sv
// Checker for the bitmap frame allocator: mode codes shared with the bench, and a
// module that watches the cfg, input and result channels, predicts and compares.
// Depends on bfa_pkg for widths and status codes.
package bfa_tb_pkg;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

module frame_alloc_checker
    import bfa_pkg::*;
    import bfa_tb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic [FRAME_W-1:0] entry_frame,
    input  logic               kernel_flag,
    input  logic               writable_flag,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [FRAME_W-1:0] new_frame,
    input  logic               present_bit,
    input  logic               rw_bit,
    input  logic               user_bit,
    output int                 fail_count,
    output int                 outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t            status;
        logic [FRAME_W-1:0] frame;
        logic               present;
        logic               rw;
        logic               user;
    } entry_update_t;

    logic [WORD_BITS-1:0] frames_in_use [WORDS];
    logic [LIMIT_W-1:0]   limit_now;
    entry_update_t        entry_updates_due [$];

    // Apply one request to the shadow bitmap and return the page entry update.
    function automatic entry_update_t predict_entry_update(
        input logic               m,
        input logic [FRAME_W-1:0] e,
        input logic               k,
        input logic               w
    );
        entry_update_t      r;
        int                 words;
        logic               found;
        logic [FRAME_W-1:0] fr;
        r.status  = ST_DONE;
        r.frame   = '0;
        r.present = 1'b0;
        r.rw      = 1'b0;
        r.user    = 1'b0;
        if (m == MODE_ALLOC) begin
            if (e != '0) begin
                r.status = ST_MAPPED;
                r.frame  = e;
            end
            else begin
                words = int'(limit_now) / WORD_BITS;
                if (words > WORDS)
                    words = WORDS;
                found = 1'b0;
                fr    = '0;
                for (int wi = 0; wi < words; wi++) begin
                    if (!found && frames_in_use[wi] != '1) begin
                        for (int b = 0; b < WORD_BITS; b++) begin
                            if (!found && !frames_in_use[wi][b]) begin
                                found = 1'b1;
                                fr    = FRAME_W'(wi * WORD_BITS + b);
                            end
                        end
                    end
                end
                if (!found)
                    r.status = ST_NO_FREE;
                else begin
                    frames_in_use[fr / WORD_BITS][fr % WORD_BITS] = 1'b1;
                    r.frame   = fr;
                    r.present = 1'b1;
                    r.rw      = w;
                    r.user    = ~k;
                end
            end
        end
        else if (e == '0)
            r.status = ST_NOTHING;
        else
            frames_in_use[e / WORD_BITS][e % WORD_BITS] = 1'b0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        int            errs;
        entry_update_t exp_upd;
        errs = 0;
        if (!rst_n) begin
            for (int i = 0; i < WORDS; i++)
                frames_in_use[i] = '0;
            limit_now = LIMIT_RESET;
            entry_updates_due.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                limit_now = cfg_data;

            // Compare first: no result can belong to a request taken at this edge.
            if (out_valid && out_ready) begin
                if (entry_updates_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d frame %0d",
                           status, new_frame);
                    errs++;
                end
                else begin
                    exp_upd = entry_updates_due.pop_front();
                    if (status !== exp_upd.status) begin
                        $error("status: expected %0d, got %0d", exp_upd.status, status);
                        errs++;
                    end
                    if (new_frame !== exp_upd.frame) begin
                        $error("new_frame: expected %0d, got %0d", exp_upd.frame, new_frame);
                        errs++;
                    end
                    if (present_bit !== exp_upd.present) begin
                        $error("present_bit: expected %0d, got %0d",
                               exp_upd.present, present_bit);
                        errs++;
                    end
                    if (rw_bit !== exp_upd.rw) begin
                        $error("rw_bit: expected %0d, got %0d", exp_upd.rw, rw_bit);
                        errs++;
                    end
                    if (user_bit !== exp_upd.user) begin
                        $error("user_bit: expected %0d, got %0d", exp_upd.user, user_bit);
                        errs++;
                    end
                end
            end

            if (in_valid && in_ready)
                entry_updates_due.push_back(
                    predict_entry_update(mode, entry_frame, kernel_flag, writable_flag));

            fail_count  <= fail_count + errs;
            outstanding <= entry_updates_due.size();
        end
    end

endmodule

>>> test/bitmap_frame_allocator_top_tb.sv
// Testbench top for the bitmap frame allocator: clock, reset, stimulus and verdict.
// Depends on bfa_pkg, bfa_tb_pkg and frame_alloc_checker; the checker does all comparing.
module bitmap_frame_allocator_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;
    import bfa_tb_pkg::*;

    // Longest stretch without any transaction before the run is declared hung.
    // A full scan reads up to 128 bitmap words; add gaps and stalls and take it many times over.
    localparam int STALL_LIMIT  = 2000;
    // Cycles allowed to pass after the last result for stray results to show.
    localparam int DRAIN_CYCLES = 140;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [FRAME_W-1:0] entry_frame;
    logic               kernel_flag;
    logic               writable_flag;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [FRAME_W-1:0] new_frame;
    logic               present_bit;
    logic               rw_bit;
    logic               user_bit;

    int                 fail_count;
    int                 outstanding;
    int                 idle_cycles;
    // Set for the last phase: no gaps on either side from then on.
    logic               quiet;
    // Frames handed out so far, drawn on to build well-formed free requests.
    logic [FRAME_W-1:0] mapped_frames [$];

    bitmap_frame_allocator_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .entry_frame   (entry_frame),
        .kernel_flag   (kernel_flag),
        .writable_flag (writable_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .new_frame     (new_frame),
        .present_bit   (present_bit),
        .rw_bit        (rw_bit),
        .user_bit      (user_bit)
    );

    frame_alloc_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .entry_frame   (entry_frame),
        .kernel_flag   (kernel_flag),
        .writable_flag (writable_flag),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .new_frame     (new_frame),
        .present_bit   (present_bit),
        .rw_bit        (rw_bit),
        .user_bit      (user_bit),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Record every frame the block hands out so that later frees can return it.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready && present_bit)
            mapped_frames.push_back(new_frame);
    end

    // Result side back-pressure: out_ready is dropped now and then between
    // stretches of readiness; hold ready high throughout the quiet phase.
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    // Watchdog: count cycles in which no transaction completes on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one request and hold it until the transaction completes. Called at a
    // clock edge; returns at the edge that takes the request, with valid still high,
    // so that a following call may either drop it for a gap or present the next one.
    task automatic offer_item(
        input logic               m,
        input logic [FRAME_W-1:0] e,
        input logic               k,
        input logic               w
    );
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        entry_frame   <= e;
        kernel_flag   <= k;
        writable_flag <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop the request channel and wait until every result has been taken.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Write frame_limit with the block idle; every request yields a result,
    // so an empty checker queue means nothing is left in flight.
    task automatic write_frame_limit(input logic [LIMIT_W-1:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random request: mostly allocations into empty entries and frees of
    // frames actually handed out, the rest noise (mapped entries, stray frees).
    task automatic issue_random_item(input int alloc_pct);
        int                 r;
        int                 idx;
        logic [FRAME_W-1:0] e;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
            offer_item(MODE_ALLOC, '0, 1'($urandom), 1'($urandom));
        else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4 && mapped_frames.size() != 0)
        begin
            idx = $urandom_range(0, mapped_frames.size() - 1);
            e   = mapped_frames[idx];
            mapped_frames.delete(idx);
            offer_item(MODE_FREE, e, 1'($urandom), 1'($urandom));
        end
        else begin
            e = FRAME_W'($urandom);
            case ($urandom_range(0, 2))
                0:       offer_item(MODE_ALLOC, e, 1'($urandom), 1'($urandom));
                1:       offer_item(MODE_FREE, e, 1'($urandom), 1'($urandom));
                default: offer_item(MODE_FREE, '0, 1'($urandom), 1'($urandom));
            endcase
        end
    endtask

    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_limits [PHASES];
        int                 alloc_pct;

        phase_limits = '{13'd32, 13'd64, 13'd4096, 13'd100, 13'd32, 13'd2048,
                         13'd8191, 13'd40, 13'd4096, 13'd96, 13'd512, 13'd4096};
        // Two phases get a limit drawn at random within the managed range.
        phase_limits[5] = LIMIT_W'($urandom_range(32, 4096));
        phase_limits[9] = LIMIT_W'($urandom_range(32, 4096));

        quiet         = 1'b0;
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        in_valid      <= 1'b0;
        mode          <= MODE_ALLOC;
        entry_frame   <= '0;
        kernel_flag   <= 1'b0;
        writable_flag <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with frame_limit at its reset value first.
        // Frame zero is an ordinary frame and is the first one handed out.
        offer_item(MODE_ALLOC, '0, 1'b0, 1'b0);
        offer_item(MODE_ALLOC, '0, 1'b1, 1'b1);
        offer_item(MODE_ALLOC, '0, 1'b0, 1'b1);
        // Entries already mapped, at both ends of the frame range.
        offer_item(MODE_ALLOC, '1, 1'b1, 1'b1);
        offer_item(MODE_ALLOC, FRAME_W'(1), 1'b0, 1'b0);
        // Nothing to free, then an ordinary free and reuse of the same frame.
        offer_item(MODE_FREE, '0, 1'b1, 1'b1);
        offer_item(MODE_FREE, FRAME_W'(1), 1'b0, 1'b0);
        offer_item(MODE_ALLOC, '0, 1'b1, 1'b0);
        // Free a frame never handed out; it still reports done.
        offer_item(MODE_FREE, '1, 1'b0, 1'b1);
        offer_item(MODE_FREE, FRAME_W'(2), 1'b1, 1'b1);
        offer_item(MODE_ALLOC, '0, 1'b1, 1'b1);

        // A limit of zero and one below a whole word search nothing at all.
        write_frame_limit('0);
        offer_item(MODE_ALLOC, '0, 1'b0, 1'b1);
        offer_item(MODE_FREE, '0, 1'b0, 1'b0);
        write_frame_limit(LIMIT_W'(31));
        offer_item(MODE_ALLOC, '0, 1'b1, 1'b0);
        // A limit beyond the bitmap searches only the words that exist.
        write_frame_limit('1);
        offer_item(MODE_ALLOC, '0, 1'b0, 1'b0);
        offer_item(MODE_ALLOC, '0, 1'b1, 1'b1);

        // Random phases: a fresh limit and allocation bias each time; small limits
        // fill up quickly and so reach the no-free-frame case again and again.
        for (int p = 0; p < PHASES; p++) begin
            write_frame_limit(phase_limits[p]);
            if (p == PHASES - 1)
                quiet = 1'b1;
            alloc_pct = $urandom_range(45, 80);
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue_random_item(alloc_pct);
        end

        // Drain, then let DRAIN_CYCLES pass for stray results.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> files.f
sv/bfa_pkg.sv
sv/bfa_ctrl.sv
sv/bfa_dp.sv
sv/bitmap_frame_allocator_top.sv
test/frame_alloc_checker.sv
test/bitmap_frame_allocator_top_tb.sv
